// ===== src/fab_pkg.sv =====
// ----------------------------------------------------------------------------
// fab_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package fab_pkg;

  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEAP_BYTES   = 65536;
  localparam int DEF_HEADER_BYTES = 20;

  // block size before clipping: header plus request, rounded up to 4
  localparam int NEED_W     = 17;
  localparam int SIZE_REG_W = 17;
  localparam int DATA_W     = 32;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_COLLECT = 2'd2;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  localparam logic [SIZE_REG_W-1:0] HEAP_SIZE_RESET = 17'h10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_APPEND,
    ST_COLL_END
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit_hit;
    logic append;
    logic coll_end;
    logic finish;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       count_zero;
    logic       scan_hit;
    logic       scan_last;
  } stat_t;

endpackage

// ===== src/first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// first-fit heap block allocator with free and collect of adjacent free blocks
// ----------------------------------------------------------------------------
// channel   direction  handshake                      word
// request   in         start, accepted when !busy     opcode, request_size,
//                                                     release_address
// result    out        done, one-cycle strobe         status, block_address
// config    in         write_enable, write_index      write_data
//
// a request walks the table (count = blocks in the table) one entry per cycle
// through the table memory read port until a hit or the last entry; an allocate
// that appends or a collect adds a wrap-up step. unknown opcode, and free or
// collect on an empty table, finish at dispatch. busy drops with the strobe
// cycle, so the next word can be taken while the result shows. reset leaves the
// table empty and needs no clearing pass. results cannot be stalled.
module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS   = fab_pkg::DEF_MAX_BLOCKS,
  parameter int HEAP_BYTES   = fab_pkg::DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = fab_pkg::DEF_HEADER_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [15:0]                request_size,
  input  logic [fab_pkg::DATA_W-1:0] release_address,
  output logic                       done,
  output logic                       status,
  output logic [fab_pkg::DATA_W-1:0] block_address,
  input  logic                       write_enable,
  input  logic                       write_index,
  input  logic [fab_pkg::DATA_W-1:0] write_data
);

  fab_pkg::cmd_t  cmd;
  fab_pkg::stat_t stat;
  logic           ctrl_busy;

  fab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (ctrl_busy)
  );

  fab_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .opcode          (opcode),
    .request_size    (request_size),
    .release_address (release_address),
    .write_enable    (write_enable),
    .write_index     (write_index),
    .write_data      (write_data),
    .cmd             (cmd),
    .stat            (stat),
    .done            (done),
    .status          (status),
    .block_address   (block_address)
  );

  assign busy = ctrl_busy;

endmodule

// ===== src/fab_ctrl.sv =====
// ----------------------------------------------------------------------------
// fab_ctrl
// request sequencer: dispatch, table walk, append and collect wrap-up
// ----------------------------------------------------------------------------
module fab_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  fab_pkg::stat_t stat,
  output fab_pkg::cmd_t  cmd,
  output logic           busy
);

  fab_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fab_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      fab_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = fab_pkg::ST_DISPATCH;
        end
      end
      fab_pkg::ST_DISPATCH: begin
        priority if (stat.op != fab_pkg::OP_ALLOC && stat.op != fab_pkg::OP_FREE &&
                     stat.op != fab_pkg::OP_COLLECT) begin
          cmd.finish = 1'b1;
          cmd.fail   = 1'b1;
          state_next = fab_pkg::ST_IDLE;
        end else if (!stat.count_zero) begin
          state_next = fab_pkg::ST_SCAN;
        end else if (stat.op == fab_pkg::OP_ALLOC) begin
          state_next = fab_pkg::ST_APPEND;
        end else begin
          // empty table: free misses, collect has nothing to do
          cmd.finish = 1'b1;
          cmd.fail   = (stat.op == fab_pkg::OP_FREE);
          state_next = fab_pkg::ST_IDLE;
        end
      end
      fab_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.scan_hit) begin
          cmd.commit_hit = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = fab_pkg::ST_IDLE;
        end else if (stat.scan_last) begin
          priority if (stat.op == fab_pkg::OP_ALLOC) begin
            state_next = fab_pkg::ST_APPEND;
          end else if (stat.op == fab_pkg::OP_FREE) begin
            cmd.finish = 1'b1;
            cmd.fail   = 1'b1;
            state_next = fab_pkg::ST_IDLE;
          end else begin
            state_next = fab_pkg::ST_COLL_END;
          end
        end
      end
      fab_pkg::ST_APPEND: begin
        cmd.append = 1'b1;
        cmd.finish = 1'b1;
        state_next = fab_pkg::ST_IDLE;
      end
      fab_pkg::ST_COLL_END: begin
        cmd.coll_end = 1'b1;
        cmd.finish   = 1'b1;
        state_next   = fab_pkg::ST_IDLE;
      end
      default: begin
        state_next = fab_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != fab_pkg::ST_IDLE);

endmodule

// ===== src/fab_datapath.sv =====
// ----------------------------------------------------------------------------
// fab_datapath
// block table memory, walk pointers, merge logic, config and result registers
// ----------------------------------------------------------------------------
module fab_datapath #(
  parameter int MAX_BLOCKS   = fab_pkg::DEF_MAX_BLOCKS,
  parameter int HEAP_BYTES   = fab_pkg::DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = fab_pkg::DEF_HEADER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    opcode,
  input  logic [15:0]                   request_size,
  input  logic [fab_pkg::DATA_W-1:0]    release_address,
  input  logic                          write_enable,
  input  logic                          write_index,
  input  logic [fab_pkg::DATA_W-1:0]    write_data,
  input  fab_pkg::cmd_t                 cmd,
  output fab_pkg::stat_t                stat,
  output logic                          done,
  output logic                          status,
  output logic [fab_pkg::DATA_W-1:0]    block_address
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int OW = $clog2(HEAP_BYTES + 1);
  localparam int SW = (OW > fab_pkg::NEED_W) ? OW : fab_pkg::NEED_W;
  localparam int NW = fab_pkg::NEED_W;

  typedef struct packed {
    logic [OW-1:0] start;
    logic [OW-1:0] size;
    logic          in_use;
  } entry_t;

  entry_t mem [MAX_BLOCKS];

  logic [fab_pkg::DATA_W-1:0]     heap_base;
  logic [fab_pkg::SIZE_REG_W-1:0] heap_size;
  logic [1:0]                     op;
  logic [NW-1:0]                  need;
  logic [fab_pkg::DATA_W-1:0]     rel;
  logic [CW-1:0]                  rd_idx;
  logic [IW-1:0]                  eval_idx;
  logic                           eval_vld;
  entry_t                         rdata;
  logic [CW-1:0]                  count;
  logic [OW-1:0]                  bump;
  logic [IW-1:0]                  wr_idx;
  entry_t                         cur;

  logic [SW-1:0]                  lim, bump_ext, need_ext;
  logic                           append_ok, alloc_hit, free_hit, merge, rd_go;
  logic [fab_pkg::DATA_W-1:0]     eval_addr, bump_addr;
  logic                           we;
  logic [IW-1:0]                  waddr;
  entry_t                         wdata;

  assign lim = (SW'(heap_size) > SW'(HEAP_BYTES)) ? SW'(HEAP_BYTES) : SW'(heap_size);
  assign bump_ext = SW'(bump);
  assign need_ext = SW'(need);
  assign append_ok = (count < CW'(MAX_BLOCKS)) && (bump_ext <= lim) &&
                     ((lim - bump_ext) >= need_ext);

  assign eval_addr = heap_base + fab_pkg::DATA_W'(rdata.start) +
                     fab_pkg::DATA_W'(HEADER_BYTES);
  assign bump_addr = heap_base + fab_pkg::DATA_W'(bump) +
                     fab_pkg::DATA_W'(HEADER_BYTES);
  assign alloc_hit = !rdata.in_use && (SW'(rdata.size) >= need_ext);
  assign free_hit  = rdata.in_use && (eval_addr == rel);
  // blocks touch end to end, so the address check of a merge normally holds
  assign merge = !cur.in_use && !rdata.in_use &&
                 (((OW+1)'(cur.start) + (OW+1)'(cur.size)) == (OW+1)'(rdata.start));
  assign rd_go = cmd.scan && (rd_idx < count);

  assign stat.op         = op;
  assign stat.count_zero = (count == '0);
  assign stat.scan_hit   = eval_vld && ((op == fab_pkg::OP_ALLOC && alloc_hit) ||
                                        (op == fab_pkg::OP_FREE && free_hit));
  assign stat.scan_last  = eval_vld && ((CW'(eval_idx) + CW'(1)) == count);

  always_comb begin
    we    = 1'b0;
    waddr = eval_idx;
    wdata = rdata;
    priority if (cmd.commit_hit) begin
      we           = 1'b1;
      wdata.in_use = (op == fab_pkg::OP_ALLOC);
    end else if (cmd.append && append_ok) begin
      we           = 1'b1;
      waddr        = count[IW-1:0];
      wdata.start  = bump;
      wdata.size   = OW'(need);
      wdata.in_use = 1'b1;
    end else if (cmd.coll_end) begin
      we    = 1'b1;
      waddr = wr_idx;
      wdata = cur;
    end else if (cmd.scan && eval_vld && op == fab_pkg::OP_COLLECT &&
                 eval_idx != '0 && !merge) begin
      // run ended: retire the accumulated block to its compacted slot
      we    = 1'b1;
      waddr = wr_idx;
      wdata = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      heap_size <= fab_pkg::HEAP_SIZE_RESET;
    end else if (write_enable) begin
      if (write_index == fab_pkg::REG_HEAP_BASE) begin
        heap_base <= write_data;
      end else begin
        heap_size <= write_data[fab_pkg::SIZE_REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      bump     <= '0;
      eval_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        eval_vld <= 1'b0;
      end else if (cmd.scan) begin
        eval_vld <= rd_go;
      end
      if (cmd.append && append_ok) begin
        count <= count + CW'(1);
        bump  <= bump + OW'(need);
      end
      if (cmd.coll_end) begin
        if (wr_idx == '0 && !cur.in_use) begin
          count <= '0;
          bump  <= '0;
        end else begin
          count <= CW'(wr_idx) + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= opcode;
      need   <= (NW'(request_size) + NW'(HEADER_BYTES) + NW'(3)) & ~NW'(3);
      rel    <= release_address;
      rd_idx <= '0;
    end else if (rd_go) begin
      rd_idx   <= rd_idx + CW'(1);
      eval_idx <= rd_idx[IW-1:0];
    end
    if (cmd.scan && eval_vld && op == fab_pkg::OP_COLLECT) begin
      if (eval_idx == '0) begin
        cur    <= rdata;
        wr_idx <= '0;
      end else if (merge) begin
        cur.size <= cur.size + rdata.size;
      end else begin
        cur    <= rdata;
        wr_idx <= wr_idx + IW'(1);
      end
    end
    if (cmd.finish) begin
      status <= cmd.fail || (cmd.append && !append_ok);
      priority if (cmd.commit_hit && op == fab_pkg::OP_ALLOC) begin
        block_address <= eval_addr;
      end else if (cmd.append && append_ok) begin
        block_address <= bump_addr;
      end else begin
        block_address <= '0;
      end
    end
  end

endmodule

// ===== src/fab_checker.sv =====
// ----------------------------------------------------------------------------
// fab_checker
// port-level checks of the allocator request and result channels
// ----------------------------------------------------------------------------
module fab_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        status,
  input logic [31:0] block_address
);

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (block_address == 32'd0))
    else $error("failed result carries an address");

  a_quiet_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!done && !busy))
    else $error("activity right after reset");

endmodule

bind first_fit_block_allocator_unit fab_checker u_fab_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .block_address (block_address)
);
